### design/sopm_pkg.sv
// shared types and constants for the square oscillator pair
// no dependencies; compiled first
package sopm_pkg;

   localparam int unsigned FREQ_W   = 15;
   localparam int unsigned COUNT_W  = 15;
   localparam int unsigned HALF_W   = 14;
   localparam int unsigned STEP_W   = 4;
   localparam int unsigned NUM_OSC  = 2;

   localparam logic [COUNT_W-1:0] TICK_HZ = 15'd31250;
   localparam logic [COUNT_W-1:0] RESET_PERIOD0 = COUNT_W'(31250 / 2005);
   localparam logic [COUNT_W-1:0] RESET_PERIOD1 = COUNT_W'(31250 / 460);
   localparam logic [HALF_W-1:0]  RESET_HALF0   = HALF_W'((31250 / 2005) / 2);
   localparam logic [HALF_W-1:0]  RESET_HALF1   = HALF_W'((31250 / 460) / 2);

   // transaction kinds on the request channel
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_SET  = 1'b1;

   // divider request and status
   typedef struct packed {
      logic               start;
      logic [FREQ_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [COUNT_W-1:0] quotient;
   } div_rsp_type;

endpackage

### design/sopm_if.sv
// request and response channel interfaces for the oscillator pair
// depends on sopm_pkg for field widths
interface sopm_req_if;
   import sopm_pkg::*;

   logic              valid;
   logic              ready;
   logic              mode;
   logic              osc_select;
   logic [FREQ_W-1:0] freq_hz;

   modport source (output valid, mode, osc_select, freq_hz, input ready);
   modport sink   (input valid, mode, osc_select, freq_hz, output ready);
endinterface

interface sopm_rsp_if;
   logic valid;
   logic ready;
   logic level;

   modport source (output valid, level, input ready);
   modport sink   (input valid, level, output ready);
endinterface

### design/sopm_div.sv
// restoring divider: tick rate divided by a frequency, one bit a cycle
// depends on sopm_pkg
module sopm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  sopm_pkg::div_req_type div_req,
   output sopm_pkg::div_rsp_type div_rsp
);
   import sopm_pkg::*;

   logic                busy_ff,  busy_in;
   logic                done_ff,  done_in;
   logic [STEP_W-1:0]   step_ff,  step_in;
   logic [COUNT_W-1:0]  rem_ff,   rem_in;
   logic [COUNT_W-1:0]  quot_ff,  quot_in;
   logic [FREQ_W-1:0]   dvsr_ff,  dvsr_in;

   logic [COUNT_W:0]    trial;
   logic [COUNT_W+1:0]  diff;
   logic                borrow;

   // shared subtract and compare
   assign trial  = {rem_ff, quot_ff[COUNT_W-1]};
   assign diff   = {1'b0, trial} - {2'b00, dvsr_ff};
   assign borrow = diff[COUNT_W+1];

   // sequencer
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dvsr_in = dvsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(COUNT_W - 1);
         rem_in  = '0;
         quot_in = TICK_HZ;
         dvsr_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in  = borrow ? trial[COUNT_W-1:0] : diff[COUNT_W-1:0];
         quot_in = {quot_ff[COUNT_W-2:0], ~borrow};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

### design/square_oscillator_pair_or_mix.sv
// top level of the square oscillator pair with ored output
// depends on sopm_pkg, sopm_if and sopm_div
//
//   channel  direction  carries
//   req_if   in         mode, osc_select, freq_hz
//   rsp_if   out        level (one per tick transaction)
//
// a tick transaction's level sits in an output register
// set transaction: starts the shared divider, runs its 15 steps, then
// updates the selected oscillator; req is not ready meanwhile
// reset (synchronous) restores periods 15 and 67 and counts equal to them
// a held response blocks new transactions until it is taken
module square_oscillator_pair_or_mix (
   input  logic       clock,
   input  logic       reset,
   sopm_req_if.sink   req_if,
   sopm_rsp_if.source rsp_if
);
   import sopm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DIV  = 2'b10
   } state_type;

   state_type           state_ff, state_in;
   logic                sel_ff, sel_in;
   logic [COUNT_W-1:0]  count_ff  [NUM_OSC];
   logic [COUNT_W-1:0]  count_in  [NUM_OSC];
   logic [COUNT_W-1:0]  period_ff [NUM_OSC];
   logic [COUNT_W-1:0]  period_in [NUM_OSC];
   logic [HALF_W-1:0]   half_ff   [NUM_OSC];
   logic [HALF_W-1:0]   half_in   [NUM_OSC];
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_level_ff, rsp_level_in;

   logic                accept;
   logic [NUM_OSC-1:0]  osc_high;
   logic [COUNT_W-1:0]  dec      [NUM_OSC];
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;

   // divider start, zero frequency taken as 1 Hz
   assign div_req.start   = accept && (req_if.mode == MODE_SET);
   assign div_req.divisor = (req_if.freq_hz == '0) ? FREQ_W'(1) : req_if.freq_hz;

   sopm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // per oscillator decrement and high-half compare
   always_comb begin
      for (int k = 0; k < NUM_OSC; k++) begin
         dec[k]      = count_ff[k] - 1'b1;
         osc_high[k] = (count_ff[k] > COUNT_W'(1)) &&
                       (dec[k] >= {1'b0, half_ff[k]});
      end
   end

   // sequencer and state update
   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      count_in     = count_ff;
      period_in    = period_ff;
      half_in      = half_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_if.mode == MODE_SET) begin
                  sel_in   = req_if.osc_select;
                  state_in = ST_DIV;
               end else begin
                  for (int k = 0; k < NUM_OSC; k++) begin
                     count_in[k] = (count_ff[k] > COUNT_W'(1)) ? dec[k] : period_ff[k];
                  end
                  rsp_valid_in = 1'b1;
                  rsp_level_in = |osc_high;
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               period_in[sel_ff] = div_rsp.quotient;
               half_in[sel_ff]   = div_rsp.quotient[COUNT_W-1:1];
               if (count_ff[sel_ff] > div_rsp.quotient) begin
                  count_in[sel_ff] = div_rsp.quotient;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff[0]  <= RESET_PERIOD0;
         count_ff[1]  <= RESET_PERIOD1;
         period_ff[0] <= RESET_PERIOD0;
         period_ff[1] <= RESET_PERIOD1;
         half_ff[0]   <= RESET_HALF0;
         half_ff[1]   <= RESET_HALF1;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         period_ff    <= period_in;
         half_ff      <= half_in;
      end
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.level = rsp_level_ff;

endmodule
